>>> rtl/serial_frame_build_and_check_macros.svh
// ----------------------------------------------------------------------------
// Serial frame builder/checker assertion macros
// Shared concurrent assertion shorthands for the frame block's checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_BUILD_AND_CHECK_MACROS_SVH
`define SERIAL_FRAME_BUILD_AND_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFBC_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame block assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame block assertion failed");

`endif

>>> rtl/sfbc_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame builder/checker package
// Shared constants, types and helper functions for the frame block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfbc_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int IO_BYTES    = 8;
  localparam int PAY_FIELDS  = 5;
  localparam int PAY_LIMIT   = FRAME_BYTES - 3;
  // Highest frame index plus one that a response check covers.
  localparam int CHK_END     = (FRAME_BYTES < IO_BYTES) ? FRAME_BYTES : IO_BYTES;

  localparam int IN_TDATA_W  = IO_BYTES * 8;
  localparam int RES_W       = IO_BYTES * 8 + 3;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [7:0] RESP_ACK      = 8'h41;
  localparam logic [7:0] RESP_NACK     = 8'h4E;
  localparam logic [7:0] SIZE_CTL_MASK = 8'h07;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NACK      = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_CMD_MISM  = 3'd3,
    ST_SIZE_BAD  = 3'd4,
    ST_CSUM_BAD  = 3'd5,
    ST_SIZE_OVER = 3'd6
  } status_e;

  typedef struct packed {
    logic                     func;
    logic [IO_BYTES-1:0][7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] sum_term;
  } lane_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [IO_BYTES-1:0][7:0] frame;
  } res_t;

  function automatic logic [2:0] pop5(logic [4:0] v);
    return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]) + 3'(v[4]);
  endfunction

  // Number of payload bytes placed for a requested size.
  function automatic logic [2:0] pay_count(logic [7:0] size);
    logic [7:0] c;
    c = (size > 8'(PAY_LIMIT)) ? 8'(PAY_LIMIT) : size;
    if (c > 8'(PAY_FIELDS)) begin
      c = 8'(PAY_FIELDS);
    end
    return c[2:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/serial_frame_build_and_check.sv
// Serial frame builder and checker. Each input transaction carries one whole
// 8-byte frame request or response, so the block takes one transaction every
// clock cycle with back-to-back traffic while the skid entry is empty. The
// result is registered in the output register after the lane and merge
// logic, or in the skid entry on a stall. Build mode (tuser = 0) outputs
// command, checksum, encoded size byte and the payload bytes inside the size,
// rest zero; status 6 flags a size above five; the command is remembered.
// In check mode (tuser = 1) the frame bytes are zero and status reports the
// first failing test: NACK, unknown response, command mismatch against the
// remembered command, bad size control bits, or bad checksum. A response
// check right after a build already sees that build's command. A two-entry
// output stage (register plus skid) lets a stalled consumer hold a result
// while the next transaction is accepted.
// ----------------------------------------------------------------------------
// Serial frame builder/checker top level
// Byte lanes, merge stage, remembered command and registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_build_and_check
  import sfbc_pkg::*;
(
  input  var logic                   clk_i,
  input  var logic                   rst_ni,
  input  var logic                   s_axis_tvalid,
  output logic                       s_axis_tready,
  // data_0 [7:0], data_1 [15:8], ... data_7 [63:56]
  input  var logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func [0]
  input  var logic                   s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  var logic                   m_axis_tready,
  // frame_0 [7:0] ... frame_7 [63:56], status [66:64], zero pad above
  output logic [OUT_TDATA_W-1:0]     m_axis_tdata
);

  item_t                item;
  lane_t [IO_BYTES-1:0] lanes;
  logic [2:0]           count;
  res_t                 res;
  logic                 in_fire;

  logic [7:0] last_cmd_q, last_cmd_d;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q, out_res_d;
  logic       skid_valid_q, skid_valid_d;
  res_t       skid_res_q, skid_res_d;

  assign item.func = s_axis_tuser;
  assign item.data = s_axis_tdata;
  assign count     = pay_count(item.data[1]);

  // One lane per input byte; each decides whether its byte is placed in the
  // frame and whether it enters the checksum.
  for (genvar j = 0; j < IO_BYTES; j++) begin : g_lane
    sfbc_lane u_lane (
      .func_i  (item.func),
      .idx_i   (3'(j)),
      .count_i (count),
      .byte_i  (item.data[j]),
      .lane_o  (lanes[j])
    );
  end

  sfbc_merge u_merge (
    .item_i     (item),
    .lanes_i    (lanes),
    .last_cmd_i (last_cmd_q),
    .res_o      (res)
  );

  // Input is refused only while the skid entry holds a result.
  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    last_cmd_d   = last_cmd_q;
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;

    // Only a build transaction updates the remembered command.
    if (in_fire && (item.func == FUNC_BUILD)) begin
      last_cmd_d = item.data[0];
    end

    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_res_d    = skid_res_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_res_d   = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_res_d   = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q   <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      last_cmd_q   <= last_cmd_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_res_q);

endmodule

`default_nettype wire

>>> rtl/sfbc_lane.sv
// ----------------------------------------------------------------------------
// Serial frame byte lane
// Qualifies one input byte for placement and for the checksum sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sfbc_lane
  import sfbc_pkg::*;
(
  input  var logic       func_i,
  input  var logic [2:0] idx_i,
  input  var logic [2:0] count_i,
  input  var logic [7:0] byte_i,
  output lane_t          lane_o
);

  logic [2:0] pay_pos;
  logic       is_payload;
  logic       placed;
  logic       chk_cover;

  assign pay_pos    = idx_i - 3'd2;
  assign is_payload = (idx_i >= 3'd2) && ({1'b0, pay_pos} < 4'(PAY_FIELDS));
  assign placed     = is_payload && (pay_pos < count_i);
  // The checksum byte itself is never summed on a check.
  assign chk_cover  = (idx_i != 3'd1) && ({1'b0, idx_i} < 4'(CHK_END));

  always_comb begin
    lane_o = '0;
    if (func_i == FUNC_BUILD) begin
      if (placed) begin
        lane_o.frame_byte = byte_i;
        lane_o.sum_term   = byte_i;
      end else if (idx_i == 3'd0) begin
        lane_o.sum_term = byte_i;
      end
    end else if (chk_cover) begin
      lane_o.sum_term = byte_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfbc_merge.sv
// ----------------------------------------------------------------------------
// Serial frame merge stage
// Sums the lane terms, folds the carry and forms the frame and status.
// ----------------------------------------------------------------------------
`default_nettype none

module sfbc_merge
  import sfbc_pkg::*;
(
  input  var item_t                item_i,
  input  var lane_t [IO_BYTES-1:0] lanes_i,
  input  var logic [7:0]           last_cmd_i,
  output res_t                     res_o
);

  logic [7:0]  size;
  logic [7:0]  enc;
  logic [11:0] sum;
  logic [7:0]  csum;
  logic [7:0]  rx_size;

  assign size    = item_i.data[1];
  assign enc     = {size[4:0], pop5(size[4:0])};
  assign rx_size = item_i.data[3];

  always_comb begin
    sum = (item_i.func == FUNC_BUILD) ? 12'(enc) : '0;
    for (int j = 0; j < IO_BYTES; j++) begin
      sum = sum + 12'(lanes_i[j].sum_term);
    end
  end

  // End-around carry is added once when the sum overflows a byte.
  assign csum = (sum[11:8] != '0) ? (sum[7:0] + 8'd1) : sum[7:0];

  always_comb begin
    res_o = '0;
    if (item_i.func == FUNC_BUILD) begin
      res_o.frame[0] = item_i.data[0];
      res_o.frame[1] = csum;
      res_o.frame[2] = enc;
      for (int j = 0; j < PAY_FIELDS; j++) begin
        res_o.frame[3 + j] = lanes_i[2 + j].frame_byte;
      end
      res_o.status = (size > 8'(PAY_LIMIT)) ? ST_SIZE_OVER : ST_OK;
    end else if (item_i.data[0] != RESP_ACK) begin
      res_o.status = (item_i.data[0] == RESP_NACK) ? ST_NACK : ST_UNKNOWN;
    end else if (item_i.data[2] != last_cmd_i) begin
      res_o.status = ST_CMD_MISM;
    end else if ((rx_size & SIZE_CTL_MASK) != {5'd0, pop5(rx_size[7:3])}) begin
      res_o.status = ST_SIZE_BAD;
    end else if (item_i.data[1] != csum) begin
      res_o.status = ST_CSUM_BAD;
    end else begin
      res_o.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfbc_checker.sv
// ----------------------------------------------------------------------------
// Serial frame builder/checker port checker
// Watches the top level's ports and flags inconsistent results over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_build_and_check_macros.svh"

module sfbc_checker
  import sfbc_pkg::*;
(
  input var logic                   clk_i,
  input var logic                   rst_ni,
  input var logic                   s_axis_tready,
  input var logic                   m_axis_tvalid,
  input var logic                   m_axis_tready,
  input var logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [2:0] status;
  logic       chk_fail;

  assign status   = m_axis_tdata[RES_W-1:RES_W-3];
  assign chk_fail = (status == ST_NACK) || (status == ST_UNKNOWN) ||
                    (status == ST_CMD_MISM) || (status == ST_SIZE_BAD) ||
                    (status == ST_CSUM_BAD);

  // A stalled result keeps its valid and its contents.
  `SFBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // The status code is always a defined one and the pad bits stay zero.
  `SFBC_ASSERT_NOW(a_status_range, clk_i, rst_ni, m_axis_tvalid,
    (status != 3'd7) && (m_axis_tdata[OUT_TDATA_W-1:RES_W] == '0))

  // A failed response check carries no frame bytes.
  `SFBC_ASSERT_NOW(a_fail_no_frame, clk_i, rst_ni, m_axis_tvalid && chk_fail,
    m_axis_tdata[IO_BYTES*8-1:0] == '0)

  // Input back-pressure only ever comes from a held result.
  `SFBC_ASSERT_NOW(a_ready_reason, clk_i, rst_ni, !s_axis_tready,
    m_axis_tvalid && $past(m_axis_tvalid))

endmodule

bind serial_frame_build_and_check sfbc_checker u_sfbc_checker (.*);

`default_nettype wire

>>> dv/serial_frame_build_and_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame builder/checker testbench
// Streams request builds and response checks into the block under random
// sender bursts and receiver stalls, predicts every result frame and status
// on the side, and compares each returned transaction field by field.
// ----------------------------------------------------------------------------

module serial_frame_build_and_check_tb;
  import sfbc_pkg::*;

  // Tracks the remembered command, works out the frame and status that each
  // accepted request must produce, and compares them with what comes back.
  class frame_result_tracker;
    typedef struct packed {
      status_e          status;
      logic [7:0][7:0]  frame;
    } frame_result_t;

    frame_result_t pending_frames[$];
    logic [7:0]    remembered_cmd;
    int            mismatches;
    int            frames_checked;
    int            builds_seen;
    int            checks_seen;
    int            status_seen[8];

    function new();
      remembered_cmd = 8'h00;
      mismatches     = 0;
      frames_checked = 0;
      builds_seen    = 0;
      checks_seen    = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    static function logic [2:0] ones5(logic [4:0] v);
      logic [2:0] n;
      int         k;
      n = 3'd0;
      for (k = 0; k < 5; k++) n += 3'(v[k]);
      return n;
    endfunction

    // End-around carry: one is added back once if the sum left 8 bits.
    static function logic [7:0] fold_carry(int sum);
      return (sum > 255) ? 8'(sum + 1) : 8'(sum);
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    function void note_request(logic func, logic [7:0][7:0] d);
      frame_result_t r;
      int            sum;
      int            count;
      int            i;
      r        = '0;
      r.status = ST_OK;
      if (func == FUNC_BUILD) begin
        builds_seen++;
        // The size byte keeps only the low five size bits in its upper part.
        r.frame[2] = {d[1][4:0], ones5(d[1][4:0])};
        count      = d[1];
        if (d[1] > 8'(PAY_LIMIT)) begin
          r.status = ST_SIZE_OVER;
          count    = PAY_LIMIT;
        end
        sum = int'(d[0]) + int'(r.frame[2]);
        for (i = 0; i < count; i++) begin
          r.frame[3 + i] = d[2 + i];
          sum += int'(d[2 + i]);
        end
        r.frame[0]     = d[0];
        r.frame[1]     = fold_carry(sum);
        remembered_cmd = d[0];
      end else begin
        checks_seen++;
        if (d[0] != RESP_ACK) begin
          r.status = (d[0] == RESP_NACK) ? ST_NACK : ST_UNKNOWN;
        end else if (d[2] != remembered_cmd) begin
          r.status = ST_CMD_MISM;
        end else if ((d[3] & SIZE_CTL_MASK) != 8'(ones5(d[3][7:3]))) begin
          r.status = ST_SIZE_BAD;
        end else begin
          // The checksum byte itself is left out of the sum.
          sum = int'(d[0]) + int'(d[2]) + int'(d[3]);
          for (i = 4; i < 8; i++) sum += int'(d[i]);
          if (d[1] != fold_carry(sum)) r.status = ST_CSUM_BAD;
        end
      end
      status_seen[int'(r.status)]++;
      pending_frames.push_back(r);
    endfunction

    function void check_frame(logic [OUT_TDATA_W-1:0] tdata);
      frame_result_t   want;
      logic [7:0][7:0] got_frame;
      logic [2:0]      got_status;
      bit              bad;
      int              i;
      got_frame  = tdata[63:0];
      got_status = tdata[66:64];
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result: frame %h status %0d",
                   $realtime, got_frame, got_status);
        end
        return;
      end
      want = pending_frames.pop_front();
      frames_checked++;
      bad = (got_status !== want.status);
      for (i = 0; i < 8; i++) begin
        if (got_frame[i] !== want.frame[i]) bad = 1'b1;
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch on result %0d: expected frame %h status %0d,",
                   $realtime, frames_checked, want.frame, want.status);
          $display("         actual frame %h status %0d", got_frame, got_status);
        end
      end
    endfunction
  endclass

  // Receiver hold-off: once this many requests have gone in, the consumer
  // stops taking results for a long stretch so that the block backs up.
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 400;
  // The sender stops and lets the block drain at this random item.
  localparam int DRAIN_AT       = 1100;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int SETTLE_CYCLES  = 8;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = FUNC_BUILD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  frame_result_tracker    sb = new();
  int                     inputs_accepted = 0;
  logic [7:0]             last_sent_cmd   = 8'h00;
  bit                     hold_done       = 1'b0;

  serial_frame_build_and_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // data_0 [7:0], data_1 [15:8], ... data_7 [63:56]
    .s_axis_tdata  (s_axis_tdata),
    // func [0]
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // frame_0 [7:0] ... frame_7 [63:56], status [66:64], zero pad above
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Both monitors sample at the rising edge, before any driver update of
  // that edge lands, so each sees the values that the handshake used.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_request(s_axis_tuser, s_axis_tdata);
      inputs_accepted <= inputs_accepted + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_frame(m_axis_tdata);
    end
  end

  // Build request: command, size, five payload bytes; data_7 is random since
  // the block must ignore it.
  function automatic logic [7:0][7:0] build_item(logic [7:0] cmd, logic [7:0] size,
                                                 logic [39:0] pay);
    logic [7:0][7:0] d;
    d[0]   = cmd;
    d[1]   = size;
    d[6:2] = pay;
    d[7]   = 8'($urandom());
    return d;
  endfunction

  // Well-formed ACK response that echoes cmd, with a correctly encoded size
  // byte and a matching checksum over the code, echo, size and payload.
  function automatic logic [7:0][7:0] valid_response(logic [7:0] cmd, logic [4:0] size,
                                                     logic [31:0] pay);
    logic [7:0][7:0] d;
    int              sum;
    int              i;
    d[0]   = RESP_ACK;
    d[2]   = cmd;
    d[3]   = {size, frame_result_tracker::ones5(size)};
    d[7:4] = pay;
    sum    = int'(d[0]) + int'(d[2]) + int'(d[3]);
    for (i = 4; i < 8; i++) sum += int'(d[i]);
    d[1]   = frame_result_tracker::fold_carry(sum);
    return d;
  endfunction

  // Offers one transaction and returns at the edge that accepts it. The
  // caller either offers the next one right away or lowers tvalid.
  task automatic send_request(input logic func, input logic [7:0][7:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (func == FUNC_BUILD) last_sent_cmd = d[0];
  endtask

  // Receiver side. It changes its stall pattern every stretch of cycles:
  // always ready, coin flip, mostly stalled, or alternating. The one long
  // hold-off lets the output stage fill and push back on the sender.
  initial begin : rx_side
    int mode;
    int stretch;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(16, 160);
      repeat (stretch) begin
        @(posedge clk_i);
        if (!hold_done && inputs_accepted >= HOLD_AT) begin
          hold_done = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready <= ~m_axis_tready;
          end
        endcase
      end
    end
  end

  // Sender side and end of test.
  initial begin : tx_side
    logic [7:0][7:0] item;
    logic [7:0]      cmd;
    logic [7:0]      size;
    int              n;
    int              burst_left;
    int              gap;
    int              kind;
    int              fault;
    int              i;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A check before any build must match the reset command.
    send_request(FUNC_CHECK, valid_response(8'h00, 5'd0, 32'h0000_0000));
    // Size zero places no payload even though every payload byte is set.
    send_request(FUNC_BUILD, build_item(8'h00, 8'd0, '1));
    // Full payload of ones: the checksum wraps and takes the carry back.
    send_request(FUNC_BUILD, build_item(8'hFF, 8'd5, '1));
    // Sizes past the limit: flagged, five bytes placed, low size bits encoded.
    send_request(FUNC_BUILD, build_item(8'h5A, 8'd6, {$urandom(), 8'($urandom())}));
    send_request(FUNC_BUILD, build_item(8'h3C, 8'd31, '1));
    send_request(FUNC_BUILD, build_item(8'hC3, 8'd255, {$urandom(), 8'($urandom())}));
    send_request(FUNC_BUILD, build_item(8'h81, 8'd32, {$urandom(), 8'($urandom())}));
    for (i = 1; i <= 4; i++) begin
      send_request(FUNC_BUILD, build_item(8'hA5, 8'(i), {$urandom(), 8'($urandom())}));
    end
    // Checks against the remembered 0xA5, the first one right after its build.
    send_request(FUNC_CHECK, valid_response(8'hA5, 5'd31, 32'hFFFF_FFFF));
    send_request(FUNC_CHECK, valid_response(8'hA5, 5'd0, 32'h0000_0000));
    item    = valid_response(8'hA5, 5'd3, $urandom());
    item[0] = RESP_NACK;
    send_request(FUNC_CHECK, item);
    // A NACK outranks a wrong echo.
    item[2] = 8'h5A;
    send_request(FUNC_CHECK, item);
    item[0] = 8'h00;
    send_request(FUNC_CHECK, item);
    item[0] = 8'hFF;
    send_request(FUNC_CHECK, item);
    item    = valid_response(8'hA5, 5'd5, $urandom());
    item[2] = 8'h5A;
    send_request(FUNC_CHECK, item);
    item    = valid_response(8'hA5, 5'd5, $urandom());
    item[3] = 8'hFF;
    send_request(FUNC_CHECK, item);
    // Bad size bits outrank a bad checksum.
    item[1] = item[1] ^ 8'h01;
    send_request(FUNC_CHECK, item);
    item    = valid_response(8'hA5, 5'd2, $urandom());
    item[1] = item[1] ^ 8'h80;
    send_request(FUNC_CHECK, item);
    // A build right before a check: the check must see the new command.
    send_request(FUNC_BUILD, build_item(8'h00, 8'd2, '0));
    send_request(FUNC_CHECK, valid_response(8'h00, 5'd2, 32'h8000_0001));

    // Random part: mostly builds and well-formed responses to the last
    // command, some with a single fault, the rest plain noise.
    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) begin
        // Let every outstanding result come back before going on.
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end else if (burst_left <= 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;

      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        cmd  = 8'($urandom());
        kind = $urandom_range(0, 6);
        if (kind <= 4) begin
          size = 8'($urandom_range(0, PAY_LIMIT));
        end else if (kind == 5) begin
          size = 8'($urandom_range(PAY_LIMIT + 1, 31));
        end else begin
          size = 8'($urandom_range(32, 255));
        end
        send_request(FUNC_BUILD, build_item(cmd, size, {$urandom(), 8'($urandom())}));
      end else if (kind < 90) begin
        item  = valid_response(last_sent_cmd, 5'($urandom()), $urandom());
        fault = $urandom_range(0, 9);
        case (fault)
          5: begin
            item[0] = RESP_NACK;
          end
          6: begin
            item[0] = 8'($urandom());
            if (item[0] == RESP_ACK) item[0] = item[0] ^ 8'h01;
          end
          7: begin
            item[2] = item[2] ^ 8'($urandom_range(1, 255));
          end
          8: begin
            item[3] = item[3] ^ 8'($urandom_range(1, 7));
          end
          9: begin
            item[1] = item[1] ^ 8'($urandom_range(1, 255));
          end
          default: begin
          end
        endcase
        send_request(FUNC_CHECK, item);
      end else begin
        send_request(1'($urandom_range(0, 1)), {$urandom(), $urandom()});
      end
    end

    // Drain, then give the output register a few more edges to misbehave.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d builds and %0d checks, %0d results compared, %0d mismatches.",
             sb.builds_seen, sb.checks_seen, sb.frames_checked, sb.mismatches);
    $display("Status mix: ok %0d, nack %0d, unknown %0d, echo %0d, size %0d, sum %0d, over %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_NACK], sb.status_seen[ST_UNKNOWN],
             sb.status_seen[ST_CMD_MISM], sb.status_seen[ST_SIZE_BAD],
             sb.status_seen[ST_CSUM_BAD], sb.status_seen[ST_SIZE_OVER]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results still outstanding.", sb.pending());
    $display("tb: failure");
    $finish;
  end

endmodule
